>>> rtl/button_press_repeat_tracker_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button press repeat tracker
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_REPEAT_TRACKER_TOP_ASSERT_SVH
`define BUTTON_PRESS_REPEAT_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication
`define BRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/brt_pkg.sv
// ---------------------------------------------------------------------------
// brt_pkg
// Shared widths, constants and types of the button press repeat tracker.
// ---------------------------------------------------------------------------
package brt_pkg;

  // Frame sample width and per-button count width
  localparam int BTN_W   = 16;
  localparam int COUNT_W = 15;

  // Reset value of the repeat delay register
  localparam logic [COUNT_W-1:0] DELAY_RESET = 15'd20;

  // Per-button flags for one frame
  typedef struct packed {
    logic pressed;
    logic repeating;
    logic trigger;
  } brt_flags_t;

endpackage

>>> rtl/brt_if.sv
// ---------------------------------------------------------------------------
// brt_in_if / brt_out_if
// Valid/ready channels carrying frame samples in and flag sets out.
// ---------------------------------------------------------------------------
interface brt_in_if import brt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] buttons;
  logic             hold_off;

  modport source (output valid, output buttons, output hold_off, input ready);
  modport sink   (input valid, input buttons, input hold_off, output ready);
endinterface

interface brt_out_if import brt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] held;
  logic [BTN_W-1:0] pressed;
  logic [BTN_W-1:0] repeating;
  logic [BTN_W-1:0] trigger;

  modport source (output valid, output held, output pressed, output repeating,
                  output trigger, input ready);
  modport sink   (input valid, input held, input pressed, input repeating,
                  input trigger, output ready);
endinterface

>>> rtl/brt_lane.sv
// ---------------------------------------------------------------------------
// brt_lane
// One button: hold counter plus a phase counter that tracks the hold count
// modulo the repeat period, so the trigger test is a compare against zero.
// ---------------------------------------------------------------------------
module brt_lane import brt_pkg::*; #(
  parameter int REPEAT_PERIOD = 20,
  parameter int WRAP_LIMIT    = 32000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,          // frame beat taken, not held off
  input  logic               down,         // button pressed in this frame
  input  logic [COUNT_W-1:0] repeat_delay,
  output brt_flags_t         flags
);

  localparam int PHASE_W = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;

  // Flags come from the count before this frame's update
  assign flags.pressed   = down && (count_r == '0);
  assign flags.repeating = down && (count_r != '0) && (count_r > repeat_delay);
  assign flags.trigger   = down && (phase_r == '0);

  // Count and phase advance together; wrap sends the count back to one
  always_comb begin
    if (!down) begin
      count_nxt = '0;
      phase_nxt = '0;
    end else if (count_r < COUNT_W'(WRAP_LIMIT)) begin
      count_nxt = count_r + COUNT_W'(1);
      phase_nxt = (phase_r == PHASE_W'(REPEAT_PERIOD - 1)) ? '0
                                                           : phase_r + PHASE_W'(1);
    end else begin
      count_nxt = COUNT_W'(1);
      phase_nxt = PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= '0;
    end else if (upd) begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> rtl/button_press_repeat_tracker_top.sv
// ---------------------------------------------------------------------------
// button_press_repeat_tracker_top
// Per-frame press, autorepeat and trigger flags for a bank of buttons.
// ---------------------------------------------------------------------------
// One frame sample is taken every cycle unless out_ch.ready stalls the pipe.
// A sample lands in an input register; when it advances, the per-button
// counters update and the flags, computed from it, land in an output
// register. Throughput is one beat per cycle, stalled only by out_ch.ready.
// All buttons update in parallel; the repeat period test uses a per-button
// phase counter, so no divider is involved. Counters clear in the reset
// cycle itself, with no clearing pass. The user writes repeat_delay (cfg_we,
// cfg_data) only while no frame is in flight; the block does not enforce it.
module button_press_repeat_tracker_top import brt_pkg::*; #(
  parameter int BUTTON_COUNT  = 16,
  parameter int REPEAT_PERIOD = 20,
  parameter int WRAP_LIMIT    = 32000
) (
  input  logic               clk,
  input  logic               rst_n,
  brt_in_if.sink             in_ch,
  brt_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data
);

  // Only the first BUTTON_COUNT sample bits, capped at BTN_W, get a lane
  localparam int LANES = (BUTTON_COUNT < BTN_W) ? BUTTON_COUNT : BTN_W;

  logic               s1_valid_r;
  logic [BTN_W-1:0]   s1_buttons_r;
  logic               s1_hold_off_r;
  logic               out_valid_r;
  logic [BTN_W-1:0]   out_held_r, out_pressed_r, out_repeating_r, out_trigger_r;
  logic [COUNT_W-1:0] repeat_delay_r;
  logic               advance;
  logic [BTN_W-1:0]   pressed_nxt, repeating_nxt, trigger_nxt;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_r <= DELAY_RESET;
    end else if (cfg_we) begin
      repeat_delay_r <= cfg_data;
    end
  end

  // Pipeline control
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_buttons_r  <= in_ch.buttons;
      s1_hold_off_r <= in_ch.hold_off;
    end
  end

  // Button lanes
  for (genvar i = 0; i < BTN_W; i++) begin : g_lane
    if (i < LANES) begin : g_on
      brt_flags_t flags;

      brt_lane #(
        .REPEAT_PERIOD (REPEAT_PERIOD),
        .WRAP_LIMIT    (WRAP_LIMIT)
      ) u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (advance && !s1_hold_off_r),
        .down         (s1_buttons_r[i]),
        .repeat_delay (repeat_delay_r),
        .flags        (flags)
      );

      assign pressed_nxt[i]   = flags.pressed;
      assign repeating_nxt[i] = flags.repeating;
      assign trigger_nxt[i]   = flags.trigger;
    end else begin : g_off
      assign pressed_nxt[i]   = 1'b0;
      assign repeating_nxt[i] = 1'b0;
      assign trigger_nxt[i]   = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_hold_off_r) begin
        out_held_r      <= '0;
        out_pressed_r   <= '0;
        out_repeating_r <= '0;
        out_trigger_r   <= '0;
      end else begin
        out_held_r      <= s1_buttons_r;
        out_pressed_r   <= pressed_nxt;
        out_repeating_r <= repeating_nxt;
        out_trigger_r   <= trigger_nxt;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.held      = out_held_r;
  assign out_ch.pressed   = out_pressed_r;
  assign out_ch.repeating = out_repeating_r;
  assign out_ch.trigger   = out_trigger_r;

  // Checks
`include "button_press_repeat_tracker_top_assert.svh"

  `BRT_ASSERT_NOW(a_pressed_is_held, out_valid_r,
    (out_pressed_r & ~out_held_r) == '0, "pressed bit without held bit")
  `BRT_ASSERT_NOW(a_pressed_not_repeating, out_valid_r,
    (out_pressed_r & out_repeating_r) == '0, "pressed and repeating together")
  `BRT_ASSERT_NOW(a_pressed_triggers, out_valid_r,
    (out_pressed_r & ~out_trigger_r) == '0, "new press without trigger")
  `BRT_ASSERT_NEXT(a_hold_off_zero, advance && s1_hold_off_r,
    out_valid_r && (out_held_r | out_pressed_r | out_repeating_r | out_trigger_r) == '0,
    "hold-off beat gave nonzero flags")

endmodule
